// ----- src/esp_frame_region_tagger_assert.svh -----
// assertion macros shared by the frame region tagger rtl
`ifndef ESP_FRAME_REGION_TAGGER_ASSERT_SVH
`define ESP_FRAME_REGION_TAGGER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define ESP_FRT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("esp frame region tagger: check failed");

// next-cycle implication, sampled on clk, off while in reset
`define ESP_FRT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("esp frame region tagger: check failed");

`endif

// ----- src/esp_frt_pkg.sv -----
// constants and code types for the esp frame region tagger
package esp_frt_pkg;

	// default width of the frame position and length state
	localparam int LENGTH_WIDTH_DEF = 16;

	// region sizes in bytes
	localparam int ETH_LEN  = 14;
	localparam int IP_LEN   = 20;
	localparam int ESPH_LEN = 8;
	localparam int IV_LEN   = 8;
	localparam int TRL_LEN  = 2;
	localparam int ICV_LEN  = 16;

	// region start positions and the shortest legal frame
	localparam int IP_START   = ETH_LEN;
	localparam int ESPH_START = IP_START + IP_LEN;
	localparam int IV_START   = ESPH_START + ESPH_LEN;
	localparam int PAY_START  = IV_START + IV_LEN;
	localparam int TAIL_LEN   = TRL_LEN + ICV_LEN;
	localparam int FIXED_LEN  = PAY_START + TAIL_LEN;

	// ip version nibble values
	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [3:0] IPV6_VERSION = 4'd6;

	// field widths
	localparam int DATA_W   = 8;
	localparam int LEN_W    = 16;
	localparam int OFFSET_W = 16;

	typedef enum logic [2:0] {
		REG_ETH   = 3'd0,
		REG_IP    = 3'd1,
		REG_ESPH  = 3'd2,
		REG_IV    = 3'd3,
		REG_PAY   = 3'd4,
		REG_TRL   = 3'd5,
		REG_ICV   = 3'd6,
		REG_OTHER = 3'd7
	} region_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADVER = 2'd1,
		ST_IPV6   = 2'd2,
		ST_SHORT  = 2'd3
	} status_t;

endpackage

// ----- src/esp_frame_region_tagger.sv -----
// esp frame region tagger: tags each frame byte with its region and offset
// A byte moves from the input register to the result register, which drives the output.
// One byte per cycle unless stalled; position, length, status update in one stage.
// A full result register with the output stalled holds the input stage too.
// Reset (arst_n low, asynchronous) empties both stages and clears position,
// length, payload end and status to zero / ok.
`include "esp_frame_region_tagger_assert.svh"

module esp_frame_region_tagger #(
	parameter int LENGTH_WIDTH = esp_frt_pkg::LENGTH_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte channel
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic [15:0] frame_length,
	// tag channel
	output logic        tag_valid,
	input  logic        tag_stall,
	output logic [2:0]  region,
	output logic [15:0] region_offset,
	output logic [1:0]  status
);
	import esp_frt_pkg::*;

	localparam int LW = LENGTH_WIDTH;
	localparam logic [LW-1:0] C_IP_START   = LW'(IP_START);
	localparam logic [LW-1:0] C_ESPH_START = LW'(ESPH_START);
	localparam logic [LW-1:0] C_IV_START   = LW'(IV_START);
	localparam logic [LW-1:0] C_PAY_START  = LW'(PAY_START);
	localparam logic [LW-1:0] C_TRL_LEN    = LW'(TRL_LEN);
	localparam logic [LW-1:0] C_TAIL_LEN   = LW'(TAIL_LEN);
	localparam logic [LW-1:0] C_FIXED_LEN  = LW'(FIXED_LEN);

	// input stage
	logic              valid_s1;
	logic [DATA_W-1:0] data_s1;
	logic              start_s1;
	logic [LEN_W-1:0]  length_s1;

	// result stage
	logic                valid_s2;
	region_t             region_s2;
	logic [OFFSET_W-1:0] offset_s2;
	status_t             status_s2;

	// per-frame state
	logic [LW-1:0] pos_q;
	logic [LW-1:0] pend_q;
	logic [LW-1:0] total_q;
	status_t       status_q;

	logic advance;
	logic load_s1;

	// handshake: result register frees when empty or taken
	assign advance    = valid_s1 && (!valid_s2 || !tag_stall);
	assign byte_stall = valid_s1 && !advance;
	assign load_s1    = byte_valid && !byte_stall;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			data_s1   <= data_byte;
			start_s1  <= frame_start;
			length_s1 <= frame_length;
		end
	end

	// frame context for this byte
	logic [LW-1:0] len_in;
	logic [LW-1:0] pos;
	logic [LW-1:0] total;
	logic [LW-1:0] pend;
	status_t       st_head;
	status_t       st_next;
	region_t       reg_next;
	logic [LW-1:0] off_next;
	logic [LW-1:0] pos_next;

	assign len_in = LW'(length_s1);

	always_comb begin
		if (start_s1) begin
			pos   = '0;
			total = len_in;
			if (len_in < C_FIXED_LEN) begin
				st_head = ST_SHORT;
				pend    = '0;
			end else begin
				st_head = ST_OK;
				pend    = len_in - C_TAIL_LEN;
			end
		end else begin
			pos     = pos_q;
			total   = total_q;
			pend    = pend_q;
			st_head = status_q;
		end
	end

	// ip version check on the first ip header byte
	always_comb begin
		st_next = st_head;
		if (st_head == ST_OK && pos == C_IP_START) begin
			if (data_s1[7:4] == IPV6_VERSION) begin
				st_next = ST_IPV6;
			end else if (data_s1[7:4] != IPV4_VERSION) begin
				st_next = ST_BADVER;
			end
		end
	end

	// region decode and offset
	always_comb begin
		reg_next = REG_OTHER;
		off_next = '0;
		if (st_next == ST_OK && pos < total) begin
			if (pos < C_IP_START) begin
				reg_next = REG_ETH;
				off_next = pos;
			end else if (pos < C_ESPH_START) begin
				reg_next = REG_IP;
				off_next = pos - C_IP_START;
			end else if (pos < C_IV_START) begin
				reg_next = REG_ESPH;
				off_next = pos - C_ESPH_START;
			end else if (pos < C_PAY_START) begin
				reg_next = REG_IV;
				off_next = pos - C_IV_START;
			end else if (pos < pend) begin
				reg_next = REG_PAY;
				off_next = pos - C_PAY_START;
			end else if (pos < pend + C_TRL_LEN) begin
				reg_next = REG_TRL;
				off_next = pos - pend;
			end else begin
				reg_next = REG_ICV;
				off_next = pos - pend - C_TRL_LEN;
			end
		end
	end

	// saturating position count
	assign pos_next = (pos == '1) ? pos : pos + 1'b1;

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pend_q   <= '0;
			total_q  <= '0;
			status_q <= ST_OK;
		end else if (advance) begin
			pos_q    <= pos_next;
			pend_q   <= pend;
			total_q  <= total;
			status_q <= st_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!tag_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			region_s2 <= reg_next;
			offset_s2 <= OFFSET_W'(off_next);
			status_s2 <= st_next;
		end
	end

	assign tag_valid     = valid_s2;
	assign region        = region_s2;
	assign region_offset = offset_s2;
	assign status        = status_s2;

	// checks
	`ESP_FRT_ASSERT_NOW(a_other_zero_offset, valid_s2 && region_s2 == REG_OTHER, offset_s2 == '0)
	`ESP_FRT_ASSERT_NOW(a_tagged_means_ok, valid_s2 && region_s2 != REG_OTHER, status_s2 == ST_OK)
	`ESP_FRT_ASSERT_NOW(a_eth_offset_range, valid_s2 && region_s2 == REG_ETH, offset_s2 < OFFSET_W'(ETH_LEN))
	`ESP_FRT_ASSERT_NOW(a_stall_only_when_held, byte_stall, valid_s1 && valid_s2 && tag_stall)
	`ESP_FRT_ASSERT_NEXT(a_advance_fills_result, advance, valid_s2)

endmodule

// ----- sim/esp_frt_checker.sv -----
// checker for the esp frame region tagger: predicts the tag of each byte and compares
module esp_frt_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	input  logic [15:0] frame_length,
	input  logic        tag_valid,
	input  logic        tag_stall,
	input  logic [2:0]  region,
	input  logic [15:0] region_offset,
	input  logic [1:0]  status,
	output int          fail_count,
	output int          pending
);
	import esp_frt_pkg::*;

	typedef struct {
		region_t     area;
		logic [15:0] offset;
		status_t     flag;
	} byte_tag_t;

	// frame tracking state of the prediction
	logic [15:0] next_pos;
	logic [15:0] frame_len;
	logic [15:0] trailer_at;
	status_t     frame_flag;
	byte_tag_t   expected_tags[$];

	// works out the tag of one byte and advances the frame position
	task automatic predict_tag(input logic [7:0] d, input logic s, input logic [15:0] len);
		logic [15:0] at;
		byte_tag_t   t;
		if (s) begin
			at = '0;
			frame_len = len;
			if (len < FIXED_LEN) begin
				frame_flag = ST_SHORT;
				trailer_at = '0;
			end else begin
				frame_flag = ST_OK;
				trailer_at = 16'(len - TAIL_LEN);
			end
		end else begin
			at = next_pos;
		end
		// version nibble of the first ip header byte
		if (frame_flag == ST_OK && at == IP_START) begin
			if (d[7:4] == IPV6_VERSION)
				frame_flag = ST_IPV6;
			else if (d[7:4] != IPV4_VERSION)
				frame_flag = ST_BADVER;
		end
		// region lookup, other once flagged or past the frame end
		t.area = REG_OTHER;
		t.offset = '0;
		if (frame_flag == ST_OK && at < frame_len) begin
			if (at < IP_START) begin
				t.area = REG_ETH;
				t.offset = at;
			end else if (at < ESPH_START) begin
				t.area = REG_IP;
				t.offset = 16'(at - IP_START);
			end else if (at < IV_START) begin
				t.area = REG_ESPH;
				t.offset = 16'(at - ESPH_START);
			end else if (at < PAY_START) begin
				t.area = REG_IV;
				t.offset = 16'(at - IV_START);
			end else if (at < trailer_at) begin
				t.area = REG_PAY;
				t.offset = 16'(at - PAY_START);
			end else if (at < trailer_at + TRL_LEN) begin
				t.area = REG_TRL;
				t.offset = 16'(at - trailer_at);
			end else begin
				t.area = REG_ICV;
				t.offset = 16'(at - trailer_at - TRL_LEN);
			end
		end
		t.flag = frame_flag;
		// position saturates at all ones
		next_pos = (at == 16'hFFFF) ? at : 16'(at + 16'd1);
		expected_tags.push_back(t);
	endtask

	// compare tag transfers against the oldest prediction, predict byte transfers
	always @(posedge clk or negedge arst_n) begin : watch
		byte_tag_t want;
		if (!arst_n) begin
			next_pos = '0;
			frame_len = '0;
			trailer_at = '0;
			frame_flag = ST_OK;
			expected_tags.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (tag_valid && !tag_stall) begin
				if (expected_tags.size() == 0) begin
					$error("tag transfer with no byte waiting for it");
					fail_count++;
				end else begin
					want = expected_tags.pop_front();
					if (region !== want.area) begin
						$error("region: expected %0d, got %0d", want.area, region);
						fail_count++;
					end
					if (region_offset !== want.offset) begin
						$error("region_offset: expected %0d, got %0d", want.offset,
							region_offset);
						fail_count++;
					end
					if (status !== want.flag) begin
						$error("status: expected %0d, got %0d", want.flag, status);
						fail_count++;
					end
				end
			end
			if (byte_valid && !byte_stall)
				predict_tag(data_byte, frame_start, frame_length);
			pending = expected_tags.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// testbench top for the esp frame region tagger: byte stimulus, tag stalls and verdict
module tb;
	import esp_frt_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic [7:0]  data_byte = '0;
	logic        frame_start = 1'b0;
	logic [15:0] frame_length = '0;
	logic        tag_stall = 1'b0;
	logic        byte_stall;
	logic        tag_valid;
	logic [2:0]  region;
	logic [15:0] region_offset;
	logic [1:0]  status;

	int fail_count;
	int pending;
	int gap_pct = 0;
	int stall_pct = 0;
	int holds_wanted = 0;
	int holds_done = 0;
	int bytes_sent = 0;

	esp_frame_region_tagger dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.frame_length (frame_length),
		.tag_valid    (tag_valid),
		.tag_stall    (tag_stall),
		.region       (region),
		.region_offset(region_offset),
		.status       (status)
	);

	esp_frt_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.frame_start  (frame_start),
		.frame_length (frame_length),
		.tag_valid    (tag_valid),
		.tag_stall    (tag_stall),
		.region       (region),
		.region_offset(region_offset),
		.status       (status),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	// clock
	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#(12 * 3000000);
		$display("simulation failed");
		$finish;
	end

	// tag side stall, with long hold-offs counted here
	initial begin
		forever begin
			@(posedge clk);
			if (holds_done < holds_wanted) begin
				holds_done++;
				tag_stall <= 1'b1;
				repeat (64) @(posedge clk);
			end else begin
				tag_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// one byte transfer, with random idle cycles ahead of it
	task automatic put_byte(input logic [7:0] d, input logic s, input logic [15:0] len);
		while ($urandom_range(99) < gap_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= d;
		frame_start <= s;
		frame_length <= len;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	// a frame of random bytes with the given version nibble at the ip header start
	task automatic send_frame(input logic [15:0] len, input int count, input logic [3:0] ver);
		logic [7:0] d;
		for (int i = 0; i < count; i++) begin
			d = 8'($urandom);
			if (i == IP_START)
				d[7:4] = ver;
			put_byte(d, i == 0, (i == 0) ? len : 16'($urandom));
		end
	endtask

	// mostly good frames, some flagged or cut short, some noise
	task automatic random_frame();
		int kind;
		int len;
		int count;
		kind = $urandom_range(99);
		if (kind < 70) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(400, 68) : $urandom_range(100, 68);
			count = len;
			if ($urandom_range(3) == 0)
				count = len + $urandom_range(4, 1);
			if ($urandom_range(9) == 0)
				count = $urandom_range(len, 1);
			send_frame(16'(len), count, IPV4_VERSION);
		end else if (kind < 80) begin
			len = $urandom_range(120, 68);
			send_frame(16'(len), $urandom_range(20, 15), 4'($urandom_range(15)));
		end else if (kind < 90) begin
			len = $urandom_range(FIXED_LEN - 1);
			send_frame(16'(len), $urandom_range(8, 1), IPV4_VERSION);
		end else begin
			count = $urandom_range(30, 1);
			repeat (count)
				put_byte(8'($urandom), $urandom_range(15) == 0, 16'($urandom));
		end
	endtask

	// stimulus and verdict
	initial begin
		int phase_end;
		int guard;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// bytes ahead of any frame start
		put_byte(8'hFF, 1'b0, 16'hFFFF);
		put_byte(8'h00, 1'b0, 16'h0000);
		// too short: zero length and one below the minimum
		send_frame(16'd0, 1, IPV4_VERSION);
		send_frame(16'(FIXED_LEN - 1), 2, IPV4_VERSION);
		// ipv6 version at the smallest legal length
		send_frame(16'(FIXED_LEN), 15, IPV6_VERSION);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					gap_pct = 0;
					stall_pct = 0;
				end
				1: begin
					gap_pct = 49;
					stall_pct = 0;
				end
				2: begin
					gap_pct = 0;
					stall_pct = 49;
				end
				default: begin
					gap_pct = 6;
					stall_pct = 6;
				end
			endcase
			// long tag hold-off while bytes keep coming
			if (p == 0)
				holds_wanted++;
			if (p == 3)
				holds_wanted++;
			phase_end = bytes_sent + 440;
			while (bytes_sent < phase_end)
				random_frame();
		end
		byte_valid <= 1'b0;

		// drain
		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (pending != 0)
			$error("%0d expected tags never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
